// File: hdl/bst_pkg.sv
// Shared types, codes and constants of the stream tokenizer.
`timescale 1ns / 1ps
package bst_pkg;

    localparam int MAX_DEPTH = 16;
    localparam int ADDR_W    = $clog2(MAX_DEPTH);
    localparam int PTR_W     = $clog2(MAX_DEPTH + 1);
    localparam int VAL_W     = 64;
    localparam int OFIFO_DEPTH = 4;
    localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);
    localparam int OFIFO_CW    = $clog2(OFIFO_DEPTH + 1);

    typedef enum logic [3:0] {
        PH_H0, PH_H1, PH_ITAG, PH_IBYTES, PH_VALUE, PH_TARR, PH_SBYTES, PH_TRAIL, PH_DRAIN
    } phase_t;

    typedef enum logic [2:0] {
        PU_VAL, PU_HDR, PU_STR, PU_ARR, PU_OBJ, PU_TKEYS, PU_ROWS, PU_REAL
    } purpose_t;

    typedef enum logic [1:0] {
        LK_ARR, LK_OBJ, LK_TKEYS, LK_TROWS
    } lkind_t;

    typedef enum logic [1:0] {
        ST_IDLE, ST_CHAIN, ST_LOAD, ST_END
    } state_t;

    typedef enum logic [3:0] {
        TK_INT, TK_REAL, TK_TRUE, TK_FALSE, TK_NULL, TK_STRLEN, TK_STRBYTE,
        TK_ARRAY, TK_OBJECT, TK_TEMPLATE, TK_ROWS, TK_SKIP, TK_END
    } tok_kind_t;

    typedef enum logic [3:0] {
        ERR_OK, ERR_HEADER, ERR_INT_TAG, ERR_TRUNC, ERR_UNK_TAG, ERR_TPL_ARR,
        ERR_NEG_COUNT, ERR_TOO_DEEP, ERR_LENGTH
    } err_t;

    // value tags
    localparam logic [7:0] TAG_ARRAY    = 8'h00;
    localparam logic [7:0] TAG_OBJECT   = 8'h01;
    localparam logic [7:0] TAG_STRING   = 8'h02;
    localparam logic [7:0] TAG_INT8     = 8'h03;
    localparam logic [7:0] TAG_INT16    = 8'h04;
    localparam logic [7:0] TAG_INT32    = 8'h05;
    localparam logic [7:0] TAG_INT64    = 8'h06;
    localparam logic [7:0] TAG_REAL     = 8'h07;
    localparam logic [7:0] TAG_TRUE     = 8'h08;
    localparam logic [7:0] TAG_FALSE    = 8'h09;
    localparam logic [7:0] TAG_NULL     = 8'h0a;
    localparam logic [7:0] TAG_TEMPLATE = 8'h0b;
    localparam logic [7:0] TAG_SKIP     = 8'h0c;
    localparam logic [7:0] HDR_BYTE0    = 8'h00;
    localparam logic [7:0] HDR_BYTE1    = 8'h01;

    typedef struct packed {
        lkind_t            kind;
        logic [VAL_W-1:0]  count;
        logic [VAL_W-1:0]  keys;
        logic [VAL_W-1:0]  index;
    } level_t;

    localparam int LEVEL_W = $bits(level_t);

    typedef struct packed {
        tok_kind_t         kind;
        logic [VAL_W-1:0]  value;
        logic [PTR_W-1:0]  depth;
        logic              is_key;
        err_t              err;
        logic              fin;
    } token_t;

    function automatic logic [3:0] int_size_of(input logic [7:0] tag);
        case (tag)
            TAG_INT8:  int_size_of = 4'd1;
            TAG_INT16: int_size_of = 4'd2;
            TAG_INT32: int_size_of = 4'd4;
            TAG_INT64: int_size_of = 4'd8;
            default:   int_size_of = 4'd0;
        endcase
    endfunction

endpackage

// File: hdl/bst_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/bst_ofifo.sv
// Small token queue between the tokenizer core and the output stream.
`timescale 1ns / 1ps
module bst_ofifo (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  bst_pkg::token_t               din,
    input  logic                          pop,
    output bst_pkg::token_t               dout,
    output logic                          valid,
    output logic [bst_pkg::OFIFO_CW-1:0]  count
);

    bst_pkg::token_t               buf_reg [bst_pkg::OFIFO_DEPTH];
    logic [bst_pkg::OFIFO_AW-1:0]  wr_reg, wr_next;
    logic [bst_pkg::OFIFO_AW-1:0]  rd_reg, rd_next;
    logic [bst_pkg::OFIFO_CW-1:0]  cnt_reg, cnt_next;
    logic                          do_pop;

    assign valid  = (cnt_reg != '0);
    assign do_pop = pop && valid;
    assign dout   = buf_reg[rd_reg];
    assign count  = cnt_reg;

    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + bst_pkg::OFIFO_CW'(push) - bst_pkg::OFIFO_CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_reg] <= din;
        end
    end

endmodule

// File: hdl/bser_stream_tokenizer.sv
// Top level: byte-serial tokenizer for one serialized buffer per frame.
//
// Input stream: one buffer byte per word on s_tdata, s_tlast on the final
// byte. Output stream: one token per word; m_tuser carries kind and key
// flag, m_tdata value, depth and error code, m_tlast the end status.
// A byte that completes no value is handled in the idle state alone. A
// byte that completes a value adds a close step (ST_CHAIN). Each nested
// level it finishes adds a pop step and, while a level remains below, a
// reload (ST_LOAD) of the new top from the level stack held in a 16-entry
// RAM. The last byte adds an end step (ST_END) for the end status. Tokens
// are pushed into the output queue as the byte is taken.
// Byte input is taken whenever the core is idle and the 4-word output
// queue has two free words, so a stalled receiver is absorbed for a few
// words before s_tready drops; nothing is lost.
// Reset (and every last byte) rearms the block to expect a header; the
// stack RAM needs no clearing since only pushed entries are read.
`timescale 1ns / 1ps
module bser_stream_tokenizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // token_value[63:0], nest_depth[68:64], error_code[72:69]
    output logic [4:0]  m_tuser,   // token_kind[3:0], is_key[4]
    output logic        m_tlast    // final_res
);

    localparam int AW = bst_pkg::ADDR_W;
    localparam int PW = bst_pkg::PTR_W;
    localparam int VW = bst_pkg::VAL_W;

    bst_pkg::state_t    st_reg, st_next;
    bst_pkg::phase_t    phase_reg, phase_next;
    bst_pkg::purpose_t  purpose_reg, purpose_next;
    logic [VW-1:0]      accum_reg, accum_next;
    logic [3:0]         left_reg, left_next;
    logic [3:0]         size_reg, size_next;
    logic [VW-1:0]      str_left_reg, str_left_next;
    logic [VW-1:0]      body_left_reg, body_left_next;
    logic [PW-1:0]      ptr_reg, ptr_next;
    logic               top_done_reg, top_done_next;
    logic               error_seen_reg, error_seen_next;
    logic               last_pend_reg, last_pend_next;
    bst_pkg::level_t    tos_reg, tos_next;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr, ram_raddr;
    bst_pkg::level_t               ram_wdata;
    logic [bst_pkg::LEVEL_W-1:0]   ram_rdata;

    logic                          emit_v;
    bst_pkg::token_t               emit_tok;
    bst_pkg::token_t               out_tok;
    logic [bst_pkg::OFIFO_CW-1:0]  fifo_cnt;
    logic                          in_acc;

    function automatic bst_pkg::token_t mk_tok(input bst_pkg::tok_kind_t k,
                                               input logic [VW-1:0] v,
                                               input logic [PW-1:0] d,
                                               input logic key);
        bst_pkg::token_t t;
        t.kind   = k;
        t.value  = v;
        t.depth  = d;
        t.is_key = key;
        t.err    = bst_pkg::ERR_OK;
        t.fin    = 1'b0;
        return t;
    endfunction

    function automatic logic in_header(input bst_pkg::phase_t ph, input bst_pkg::purpose_t pu);
        in_header = (ph == bst_pkg::PH_H0) || (ph == bst_pkg::PH_H1) ||
                    (((ph == bst_pkg::PH_ITAG) || (ph == bst_pkg::PH_IBYTES)) &&
                     (pu == bst_pkg::PU_HDR));
    endfunction

    assign s_tready = (st_reg == bst_pkg::ST_IDLE) &&
                      (fifo_cnt <= bst_pkg::OFIFO_CW'(bst_pkg::OFIFO_DEPTH - 2));
    assign in_acc   = s_tvalid && s_tready;

    bst_ram #(
        .WIDTH(bst_pkg::LEVEL_W),
        .DEPTH(bst_pkg::MAX_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bst_ofifo u_ofifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (emit_v),
        .din   (emit_tok),
        .pop   (m_tready),
        .dout  (out_tok),
        .valid (m_tvalid),
        .count (fifo_cnt)
    );

    assign m_tdata = {7'd0, out_tok.err, out_tok.depth, out_tok.value};
    assign m_tuser = {out_tok.is_key, out_tok.kind};
    assign m_tlast = out_tok.fin;

    always_comb
    begin
        logic [3:0]        sz;
        logic [2:0]        pos;
        logic [VW-1:0]     acc_new;
        logic [VW-1:0]     v;
        logic              do_fail;
        bst_pkg::err_t     fail_code;
        logic              do_chain;
        logic              do_pop;
        logic              do_push;
        bst_pkg::level_t   push_lvl;
        logic              key_ctx;
        logic [PW-1:0]     ptr_m1;
        logic [VW-1:0]     cnt_dec;
        logic [VW-1:0]     idx_inc;
        logic              dec;
        logic              finish;
        bst_pkg::err_t     end_code;

        st_next         = st_reg;
        phase_next      = phase_reg;
        purpose_next    = purpose_reg;
        accum_next      = accum_reg;
        left_next       = left_reg;
        size_next       = size_reg;
        str_left_next   = str_left_reg;
        body_left_next  = body_left_reg;
        ptr_next        = ptr_reg;
        top_done_next   = top_done_reg;
        error_seen_next = error_seen_reg;
        last_pend_next  = last_pend_reg;
        tos_next        = tos_reg;

        emit_v    = 1'b0;
        emit_tok  = mk_tok(bst_pkg::TK_INT, '0, '0, 1'b0);
        do_fail   = 1'b0;
        fail_code = bst_pkg::ERR_OK;
        do_chain  = 1'b0;
        do_pop    = 1'b0;
        do_push   = 1'b0;
        push_lvl  = tos_reg;
        dec       = 1'b0;
        finish    = 1'b0;
        end_code  = bst_pkg::ERR_OK;

        ptr_m1    = ptr_reg - 1'b1;
        ram_we    = 1'b0;
        ram_waddr = ptr_m1[AW-1:0];
        ram_wdata = tos_reg;
        ram_raddr = AW'(ptr_reg - PW'(2));
        key_ctx   = (ptr_reg != '0) && (tos_reg.kind == bst_pkg::LK_OBJ) &&
                    (tos_reg.index == '0);
        cnt_dec   = tos_reg.count - 1'b1;
        idx_inc   = tos_reg.index + 1'b1;

        sz      = bst_pkg::int_size_of(s_tdata);
        pos     = 3'(size_reg - left_reg);
        acc_new = accum_reg | ({56'd0, s_tdata} << {pos, 3'b000});
        case (size_reg)
            4'd1:    v = {{56{acc_new[7]}},  acc_new[7:0]};
            4'd2:    v = {{48{acc_new[15]}}, acc_new[15:0]};
            4'd4:    v = {{32{acc_new[31]}}, acc_new[31:0]};
            default: v = acc_new;
        endcase

        case (st_reg)
            bst_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (!in_header(phase_reg, purpose_reg) && (phase_reg != bst_pkg::PH_DRAIN))
                    begin
                        body_left_next = body_left_reg - 1'b1;
                    end
                    case (phase_reg)
                        bst_pkg::PH_H0:
                        begin
                            if (s_tdata != bst_pkg::HDR_BYTE0)
                            begin
                                do_fail = 1'b1; fail_code = bst_pkg::ERR_HEADER;
                            end
                            else
                            begin
                                phase_next = bst_pkg::PH_H1;
                            end
                        end
                        bst_pkg::PH_H1:
                        begin
                            if (s_tdata != bst_pkg::HDR_BYTE1)
                            begin
                                do_fail = 1'b1; fail_code = bst_pkg::ERR_HEADER;
                            end
                            else
                            begin
                                phase_next   = bst_pkg::PH_ITAG;
                                purpose_next = bst_pkg::PU_HDR;
                            end
                        end
                        bst_pkg::PH_ITAG:
                        begin
                            if (sz == 4'd0)
                            begin
                                do_fail   = 1'b1;
                                fail_code = (purpose_reg == bst_pkg::PU_HDR) ?
                                            bst_pkg::ERR_HEADER : bst_pkg::ERR_INT_TAG;
                            end
                            else
                            begin
                                accum_next = '0; size_next = sz; left_next = sz;
                                phase_next = bst_pkg::PH_IBYTES;
                            end
                        end
                        bst_pkg::PH_IBYTES:
                        begin
                            accum_next = acc_new;
                            left_next  = left_reg - 1'b1;
                            if (left_reg == 4'd1)
                            begin
                                case (purpose_reg)
                                    bst_pkg::PU_HDR:
                                    begin
                                        body_left_next = v;
                                        phase_next     = bst_pkg::PH_VALUE;
                                    end
                                    bst_pkg::PU_VAL, bst_pkg::PU_REAL:
                                    begin
                                        emit_v   = 1'b1;
                                        emit_tok = mk_tok((purpose_reg == bst_pkg::PU_VAL) ?
                                                          bst_pkg::TK_INT : bst_pkg::TK_REAL,
                                                          v, ptr_reg, 1'b0);
                                        do_chain = 1'b1;
                                    end
                                    bst_pkg::PU_STR:
                                    begin
                                        if (v[VW-1])
                                        begin
                                            do_fail = 1'b1; fail_code = bst_pkg::ERR_NEG_COUNT;
                                        end
                                        else
                                        begin
                                            emit_v   = 1'b1;
                                            emit_tok = mk_tok(bst_pkg::TK_STRLEN, v, ptr_reg,
                                                              key_ctx);
                                            if (v == '0)
                                            begin
                                                do_chain = 1'b1;
                                            end
                                            else
                                            begin
                                                str_left_next = v;
                                                phase_next    = bst_pkg::PH_SBYTES;
                                            end
                                        end
                                    end
                                    bst_pkg::PU_ARR, bst_pkg::PU_OBJ:
                                    begin
                                        if (v[VW-1])
                                        begin
                                            do_fail = 1'b1; fail_code = bst_pkg::ERR_NEG_COUNT;
                                        end
                                        else if ((v != '0) &&
                                                 (ptr_reg >= PW'(bst_pkg::MAX_DEPTH)))
                                        begin
                                            do_fail = 1'b1; fail_code = bst_pkg::ERR_TOO_DEEP;
                                        end
                                        else
                                        begin
                                            emit_v   = 1'b1;
                                            emit_tok = mk_tok((purpose_reg == bst_pkg::PU_ARR) ?
                                                              bst_pkg::TK_ARRAY :
                                                              bst_pkg::TK_OBJECT,
                                                              v, ptr_reg, 1'b0);
                                            if (v == '0)
                                            begin
                                                do_chain = 1'b1;
                                            end
                                            else
                                            begin
                                                do_push        = 1'b1;
                                                push_lvl.kind  = (purpose_reg == bst_pkg::PU_ARR) ?
                                                                 bst_pkg::LK_ARR :
                                                                 bst_pkg::LK_OBJ;
                                                push_lvl.count = v;
                                                push_lvl.keys  = '0;
                                                push_lvl.index = '0;
                                                phase_next     = bst_pkg::PH_VALUE;
                                            end
                                        end
                                    end
                                    bst_pkg::PU_TKEYS:
                                    begin
                                        if (v[VW-1])
                                        begin
                                            do_fail = 1'b1; fail_code = bst_pkg::ERR_NEG_COUNT;
                                        end
                                        else if (ptr_reg >= PW'(bst_pkg::MAX_DEPTH))
                                        begin
                                            do_fail = 1'b1; fail_code = bst_pkg::ERR_TOO_DEEP;
                                        end
                                        else
                                        begin
                                            emit_v   = 1'b1;
                                            emit_tok = mk_tok(bst_pkg::TK_TEMPLATE, v, ptr_reg,
                                                              1'b0);
                                            do_push        = 1'b1;
                                            push_lvl.kind  = bst_pkg::LK_TKEYS;
                                            push_lvl.count = v;
                                            push_lvl.keys  = v;
                                            push_lvl.index = '0;
                                            if (v == '0)
                                            begin
                                                phase_next   = bst_pkg::PH_ITAG;
                                                purpose_next = bst_pkg::PU_ROWS;
                                            end
                                            else
                                            begin
                                                phase_next = bst_pkg::PH_VALUE;
                                            end
                                        end
                                    end
                                    default:
                                    begin
                                        // row count of a template
                                        if (v[VW-1])
                                        begin
                                            do_fail = 1'b1; fail_code = bst_pkg::ERR_NEG_COUNT;
                                        end
                                        else
                                        begin
                                            emit_v   = 1'b1;
                                            emit_tok = mk_tok(bst_pkg::TK_ROWS, v, ptr_m1, 1'b0);
                                            if ((v == '0) || (tos_reg.keys == '0))
                                            begin
                                                do_pop = 1'b1;
                                            end
                                            else
                                            begin
                                                tos_next.kind  = bst_pkg::LK_TROWS;
                                                tos_next.count = v;
                                                tos_next.index = '0;
                                                phase_next     = bst_pkg::PH_VALUE;
                                            end
                                        end
                                    end
                                endcase
                            end
                        end
                        bst_pkg::PH_VALUE:
                        begin
                            if (key_ctx)
                            begin
                                if (s_tdata != bst_pkg::TAG_STRING)
                                begin
                                    do_fail = 1'b1; fail_code = bst_pkg::ERR_UNK_TAG;
                                end
                                else
                                begin
                                    phase_next   = bst_pkg::PH_ITAG;
                                    purpose_next = bst_pkg::PU_STR;
                                end
                            end
                            else if ((s_tdata == bst_pkg::TAG_SKIP) && (ptr_reg != '0) &&
                                     (tos_reg.kind == bst_pkg::LK_TROWS))
                            begin
                                emit_v   = 1'b1;
                                emit_tok = mk_tok(bst_pkg::TK_SKIP, '0, ptr_reg, 1'b0);
                                do_chain = 1'b1;
                            end
                            else if (sz != 4'd0)
                            begin
                                accum_next = '0; size_next = sz; left_next = sz;
                                purpose_next = bst_pkg::PU_VAL;
                                phase_next   = bst_pkg::PH_IBYTES;
                            end
                            else
                            begin
                                case (s_tdata)
                                    bst_pkg::TAG_ARRAY:
                                    begin
                                        phase_next = bst_pkg::PH_ITAG;
                                        purpose_next = bst_pkg::PU_ARR;
                                    end
                                    bst_pkg::TAG_OBJECT:
                                    begin
                                        phase_next = bst_pkg::PH_ITAG;
                                        purpose_next = bst_pkg::PU_OBJ;
                                    end
                                    bst_pkg::TAG_STRING:
                                    begin
                                        phase_next = bst_pkg::PH_ITAG;
                                        purpose_next = bst_pkg::PU_STR;
                                    end
                                    bst_pkg::TAG_REAL:
                                    begin
                                        accum_next = '0; size_next = 4'd8; left_next = 4'd8;
                                        purpose_next = bst_pkg::PU_REAL;
                                        phase_next   = bst_pkg::PH_IBYTES;
                                    end
                                    bst_pkg::TAG_TRUE:
                                    begin
                                        emit_v = 1'b1; do_chain = 1'b1;
                                        emit_tok = mk_tok(bst_pkg::TK_TRUE, '0, ptr_reg, 1'b0);
                                    end
                                    bst_pkg::TAG_FALSE:
                                    begin
                                        emit_v = 1'b1; do_chain = 1'b1;
                                        emit_tok = mk_tok(bst_pkg::TK_FALSE, '0, ptr_reg, 1'b0);
                                    end
                                    bst_pkg::TAG_NULL:
                                    begin
                                        emit_v = 1'b1; do_chain = 1'b1;
                                        emit_tok = mk_tok(bst_pkg::TK_NULL, '0, ptr_reg, 1'b0);
                                    end
                                    bst_pkg::TAG_TEMPLATE:
                                    begin
                                        phase_next = bst_pkg::PH_TARR;
                                    end
                                    default:
                                    begin
                                        do_fail = 1'b1; fail_code = bst_pkg::ERR_UNK_TAG;
                                    end
                                endcase
                            end
                        end
                        bst_pkg::PH_TARR:
                        begin
                            if (s_tdata != bst_pkg::TAG_ARRAY)
                            begin
                                do_fail = 1'b1; fail_code = bst_pkg::ERR_TPL_ARR;
                            end
                            else
                            begin
                                phase_next   = bst_pkg::PH_ITAG;
                                purpose_next = bst_pkg::PU_TKEYS;
                            end
                        end
                        bst_pkg::PH_SBYTES:
                        begin
                            emit_v   = 1'b1;
                            emit_tok = mk_tok(bst_pkg::TK_STRBYTE, {56'd0, s_tdata}, ptr_reg,
                                              key_ctx);
                            str_left_next = str_left_reg - 1'b1;
                            if (str_left_reg == 64'd1)
                            begin
                                do_chain = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase

                    if (do_push)
                    begin
                        // spill the current top into the stack RAM
                        ram_we   = (ptr_reg != '0);
                        tos_next = push_lvl;
                        ptr_next = ptr_reg + 1'b1;
                    end
                    if (do_pop)
                    begin
                        ptr_next = ptr_m1;
                        st_next  = (ptr_m1 != '0) ? bst_pkg::ST_LOAD : bst_pkg::ST_CHAIN;
                    end
                    else if (do_chain)
                    begin
                        st_next = bst_pkg::ST_CHAIN;
                    end
                    if (do_fail)
                    begin
                        emit_v          = 1'b1;
                        emit_tok        = mk_tok(bst_pkg::TK_END, '0, '0, 1'b0);
                        emit_tok.err    = fail_code;
                        emit_tok.fin    = 1'b1;
                        error_seen_next = 1'b1;
                        phase_next      = bst_pkg::PH_DRAIN;
                    end
                    if (s_tlast)
                    begin
                        last_pend_next = 1'b1;
                        if (st_next == bst_pkg::ST_IDLE)
                        begin
                            st_next = bst_pkg::ST_END;
                        end
                    end
                end
            end

            bst_pkg::ST_CHAIN:
            begin
                // one step of closing finished levels
                if (ptr_reg == '0)
                begin
                    top_done_next = 1'b1;
                    phase_next    = bst_pkg::PH_TRAIL;
                    finish        = 1'b1;
                end
                else
                begin
                    phase_next = bst_pkg::PH_VALUE;
                    case (tos_reg.kind)
                        bst_pkg::LK_OBJ:
                        begin
                            if (tos_reg.index == '0)
                            begin
                                tos_next.index = 64'd1;
                                finish = 1'b1;
                            end
                            else
                            begin
                                tos_next.index = '0;
                                dec = 1'b1;
                            end
                        end
                        bst_pkg::LK_TKEYS:
                        begin
                            tos_next.count = cnt_dec;
                            if (cnt_dec == '0)
                            begin
                                phase_next   = bst_pkg::PH_ITAG;
                                purpose_next = bst_pkg::PU_ROWS;
                            end
                            finish = 1'b1;
                        end
                        bst_pkg::LK_TROWS:
                        begin
                            tos_next.index = idx_inc;
                            if (idx_inc != tos_reg.keys)
                            begin
                                finish = 1'b1;
                            end
                            else
                            begin
                                tos_next.index = '0;
                                dec = 1'b1;
                            end
                        end
                        default:
                        begin
                            dec = 1'b1;
                        end
                    endcase
                    if (dec)
                    begin
                        tos_next.count = cnt_dec;
                        if (cnt_dec != '0)
                        begin
                            finish = 1'b1;
                        end
                        else
                        begin
                            ptr_next = ptr_m1;
                            if (ptr_m1 != '0)
                            begin
                                st_next = bst_pkg::ST_LOAD;
                            end
                        end
                    end
                end
                if (finish)
                begin
                    st_next = last_pend_reg ? bst_pkg::ST_END : bst_pkg::ST_IDLE;
                end
            end

            bst_pkg::ST_LOAD:
            begin
                tos_next = bst_pkg::level_t'(ram_rdata);
                st_next  = bst_pkg::ST_CHAIN;
            end

            bst_pkg::ST_END:
            begin
                if (in_header(phase_reg, purpose_reg))
                begin
                    end_code = bst_pkg::ERR_HEADER;
                end
                else if (body_left_reg != '0)
                begin
                    end_code = bst_pkg::ERR_LENGTH;
                end
                else if (!top_done_reg)
                begin
                    end_code = bst_pkg::ERR_TRUNC;
                end
                emit_v          = !error_seen_reg;
                emit_tok        = mk_tok(bst_pkg::TK_END, '0, '0, 1'b0);
                emit_tok.err    = end_code;
                emit_tok.fin    = 1'b1;
                phase_next      = bst_pkg::PH_H0;
                purpose_next    = bst_pkg::PU_VAL;
                accum_next      = '0;
                left_next       = '0;
                size_next       = '0;
                str_left_next   = '0;
                body_left_next  = '0;
                ptr_next        = '0;
                top_done_next   = 1'b0;
                error_seen_next = 1'b0;
                last_pend_next  = 1'b0;
                st_next         = bst_pkg::ST_IDLE;
            end

            default:
            begin
                st_next = bst_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= bst_pkg::ST_IDLE;
            phase_reg      <= bst_pkg::PH_H0;
            purpose_reg    <= bst_pkg::PU_VAL;
            accum_reg      <= '0;
            left_reg       <= '0;
            size_reg       <= '0;
            str_left_reg   <= '0;
            body_left_reg  <= '0;
            ptr_reg        <= '0;
            top_done_reg   <= 1'b0;
            error_seen_reg <= 1'b0;
            last_pend_reg  <= 1'b0;
        end
        else
        begin
            st_reg         <= st_next;
            phase_reg      <= phase_next;
            purpose_reg    <= purpose_next;
            accum_reg      <= accum_next;
            left_reg       <= left_next;
            size_reg       <= size_next;
            str_left_reg   <= str_left_next;
            body_left_reg  <= body_left_next;
            ptr_reg        <= ptr_next;
            top_done_reg   <= top_done_next;
            error_seen_reg <= error_seen_next;
            last_pend_reg  <= last_pend_next;
        end
    end

    // top of stack lives in flops; lower levels in the RAM
    always_ff @(posedge clk)
    begin
        tos_reg <= tos_next;
    end

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= PW'(bst_pkg::MAX_DEPTH))
        else $error("stack pointer beyond depth");

    a_load_then_chain: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == bst_pkg::ST_LOAD) |=> (st_reg == bst_pkg::ST_CHAIN))
        else $error("stack reload not followed by close step");

    a_room_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> (fifo_cnt <= bst_pkg::OFIFO_CW'(bst_pkg::OFIFO_DEPTH - 2)))
        else $error("byte taken without room for its tokens");

    a_write_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((st_reg == bst_pkg::ST_IDLE) && in_acc))
        else $error("stack write outside a byte step");

    a_end_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == bst_pkg::ST_END) |=> ((ptr_reg == '0) && (phase_reg == bst_pkg::PH_H0)))
        else $error("end of buffer did not rearm");

endmodule

// File: verif/testbench.sv
// Testbench for the byte-serial tokenizer: predicted tokens checked per word.
`timescale 1ns / 1ps
module testbench;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } byte_item_t;

    typedef struct {
        bst_pkg::tok_kind_t kind;
        logic [63:0]        value;
        logic [4:0]         depth;
        logic               is_key;
        bst_pkg::err_t      err;
        logic               fin;
    } token_exp_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic [4:0]  m_tuser;
    logic        m_tlast;

    bser_stream_tokenizer dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    byte_item_t pending_bytes[$];
    token_exp_t expected_tokens[$];
    int  fail_count;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  stim_done;
    longint cycle_count;

    // predictor state
    bst_pkg::phase_t   p_phase;
    logic [63:0]       p_accum;
    int                p_int_left;
    int                p_int_size;
    bst_pkg::purpose_t p_purpose;
    logic [63:0]       p_str_left;
    logic [63:0]       p_body_left;
    bst_pkg::lkind_t   p_lkind[bst_pkg::MAX_DEPTH];
    logic [63:0]       p_lcount[bst_pkg::MAX_DEPTH];
    logic [63:0]       p_lkeys[bst_pkg::MAX_DEPTH];
    logic [63:0]       p_lindex[bst_pkg::MAX_DEPTH];
    int                p_ptr;
    bit                p_top_done;
    bit                p_err_seen;
    int                p_emitted;

    function automatic void push_token(bst_pkg::tok_kind_t k, logic [63:0] v, int d, bit key,
                                       bst_pkg::err_t e, bit f);
        token_exp_t t;
        if (p_emitted >= 2) return;
        t.kind = k; t.value = v; t.depth = d[4:0]; t.is_key = key; t.err = e; t.fin = f;
        expected_tokens.push_back(t);
        p_emitted++;
    endfunction

    function automatic void tok_reset();
        p_phase = bst_pkg::PH_H0; p_accum = '0; p_int_left = 0; p_int_size = 0;
        p_purpose = bst_pkg::PU_VAL; p_str_left = '0; p_body_left = '0;
        p_ptr = 0; p_top_done = 0; p_err_seen = 0;
    endfunction

    function automatic void tok_fail(bst_pkg::err_t e);
        push_token(bst_pkg::TK_END, '0, 0, 0, e, 1);
        p_err_seen = 1;
        p_phase = bst_pkg::PH_DRAIN;
    endfunction

    function automatic bit in_key_slot();
        return p_ptr > 0 && p_lkind[p_ptr-1] == bst_pkg::LK_OBJ && p_lindex[p_ptr-1] == 0;
    endfunction

    function automatic int tag_size(logic [7:0] b);
        case (b)
            bst_pkg::TAG_INT8:  return 1;
            bst_pkg::TAG_INT16: return 2;
            bst_pkg::TAG_INT32: return 4;
            bst_pkg::TAG_INT64: return 8;
            default:            return 0;
        endcase
    endfunction

    function automatic void close_value();
        int t;
        forever begin
            if (p_ptr == 0)
            begin
                p_top_done = 1; p_phase = bst_pkg::PH_TRAIL; return;
            end
            t = p_ptr - 1;
            p_phase = bst_pkg::PH_VALUE;
            case (p_lkind[t])
                bst_pkg::LK_OBJ:
                begin
                    if (p_lindex[t] == 0)
                    begin
                        p_lindex[t] = 1; return;
                    end
                    p_lindex[t] = 0;
                end
                bst_pkg::LK_TKEYS:
                begin
                    p_lcount[t]--;
                    if (p_lcount[t] == 0)
                    begin
                        p_phase = bst_pkg::PH_ITAG; p_purpose = bst_pkg::PU_ROWS;
                    end
                    return;
                end
                bst_pkg::LK_TROWS:
                begin
                    p_lindex[t]++;
                    if (p_lindex[t] != p_lkeys[t]) return;
                    p_lindex[t] = 0;
                end
                default: ;
            endcase
            p_lcount[t]--;
            if (p_lcount[t] != 0) return;
            p_ptr--;
        end
    endfunction

    function automatic void open_level(bst_pkg::lkind_t k, logic [63:0] c, logic [63:0] keys);
        p_lkind[p_ptr] = k; p_lcount[p_ptr] = c; p_lkeys[p_ptr] = keys;
        p_lindex[p_ptr] = 0; p_ptr++;
    endfunction

    function automatic void start_int(int sz, bst_pkg::purpose_t pu);
        p_accum = '0; p_int_size = sz; p_int_left = sz; p_purpose = pu;
        p_phase = bst_pkg::PH_IBYTES;
    endfunction

    function automatic void finish_int();
        logic [63:0] v;
        logic [63:0] mask;
        bit neg;
        int t;
        v = p_accum;
        if (p_int_size < 8)
        begin
            mask = (64'd1 << (8 * p_int_size)) - 1;
            v &= mask;
            if (v[8*p_int_size-1]) v |= ~mask;
        end
        neg = v[63];
        case (p_purpose)
            bst_pkg::PU_HDR:
            begin
                p_body_left = v; p_phase = bst_pkg::PH_VALUE;
            end
            bst_pkg::PU_VAL:
            begin
                push_token(bst_pkg::TK_INT, v, p_ptr, 0, bst_pkg::ERR_OK, 0); close_value();
            end
            bst_pkg::PU_REAL:
            begin
                push_token(bst_pkg::TK_REAL, v, p_ptr, 0, bst_pkg::ERR_OK, 0); close_value();
            end
            bst_pkg::PU_STR:
            begin
                if (neg) tok_fail(bst_pkg::ERR_NEG_COUNT);
                else
                begin
                    push_token(bst_pkg::TK_STRLEN, v, p_ptr, in_key_slot(), bst_pkg::ERR_OK, 0);
                    if (v == 0) close_value();
                    else
                    begin
                        p_str_left = v; p_phase = bst_pkg::PH_SBYTES;
                    end
                end
            end
            bst_pkg::PU_ARR, bst_pkg::PU_OBJ:
            begin
                if (neg) tok_fail(bst_pkg::ERR_NEG_COUNT);
                else if (v != 0 && p_ptr >= bst_pkg::MAX_DEPTH) tok_fail(bst_pkg::ERR_TOO_DEEP);
                else
                begin
                    push_token(p_purpose == bst_pkg::PU_ARR ? bst_pkg::TK_ARRAY :
                               bst_pkg::TK_OBJECT, v, p_ptr, 0, bst_pkg::ERR_OK, 0);
                    if (v == 0) close_value();
                    else
                    begin
                        open_level(p_purpose == bst_pkg::PU_ARR ? bst_pkg::LK_ARR :
                                   bst_pkg::LK_OBJ, v, 0);
                        p_phase = bst_pkg::PH_VALUE;
                    end
                end
            end
            bst_pkg::PU_TKEYS:
            begin
                if (neg) tok_fail(bst_pkg::ERR_NEG_COUNT);
                else if (p_ptr >= bst_pkg::MAX_DEPTH) tok_fail(bst_pkg::ERR_TOO_DEEP);
                else
                begin
                    push_token(bst_pkg::TK_TEMPLATE, v, p_ptr, 0, bst_pkg::ERR_OK, 0);
                    open_level(bst_pkg::LK_TKEYS, v, v);
                    if (v == 0)
                    begin
                        p_phase = bst_pkg::PH_ITAG; p_purpose = bst_pkg::PU_ROWS;
                    end
                    else p_phase = bst_pkg::PH_VALUE;
                end
            end
            default:
            begin
                if (neg) tok_fail(bst_pkg::ERR_NEG_COUNT);
                else
                begin
                    t = p_ptr - 1;
                    push_token(bst_pkg::TK_ROWS, v, t, 0, bst_pkg::ERR_OK, 0);
                    if (v == 0 || p_lkeys[t] == 0)
                    begin
                        p_ptr--; close_value();
                    end
                    else
                    begin
                        p_lkind[t] = bst_pkg::LK_TROWS; p_lcount[t] = v; p_lindex[t] = 0;
                        p_phase = bst_pkg::PH_VALUE;
                    end
                end
            end
        endcase
    endfunction

    function automatic void value_tag(logic [7:0] b);
        int sz;
        sz = tag_size(b);
        if (in_key_slot())
        begin
            if (b != bst_pkg::TAG_STRING) tok_fail(bst_pkg::ERR_UNK_TAG);
            else
            begin
                p_phase = bst_pkg::PH_ITAG; p_purpose = bst_pkg::PU_STR;
            end
            return;
        end
        if (b == bst_pkg::TAG_SKIP && p_ptr > 0 && p_lkind[p_ptr-1] == bst_pkg::LK_TROWS)
        begin
            push_token(bst_pkg::TK_SKIP, '0, p_ptr, 0, bst_pkg::ERR_OK, 0);
            close_value();
            return;
        end
        if (sz != 0)
        begin
            start_int(sz, bst_pkg::PU_VAL); return;
        end
        case (b)
            bst_pkg::TAG_ARRAY:
            begin
                p_phase = bst_pkg::PH_ITAG; p_purpose = bst_pkg::PU_ARR;
            end
            bst_pkg::TAG_OBJECT:
            begin
                p_phase = bst_pkg::PH_ITAG; p_purpose = bst_pkg::PU_OBJ;
            end
            bst_pkg::TAG_STRING:
            begin
                p_phase = bst_pkg::PH_ITAG; p_purpose = bst_pkg::PU_STR;
            end
            bst_pkg::TAG_REAL: start_int(8, bst_pkg::PU_REAL);
            bst_pkg::TAG_TRUE:
            begin
                push_token(bst_pkg::TK_TRUE, '0, p_ptr, 0, bst_pkg::ERR_OK, 0); close_value();
            end
            bst_pkg::TAG_FALSE:
            begin
                push_token(bst_pkg::TK_FALSE, '0, p_ptr, 0, bst_pkg::ERR_OK, 0); close_value();
            end
            bst_pkg::TAG_NULL:
            begin
                push_token(bst_pkg::TK_NULL, '0, p_ptr, 0, bst_pkg::ERR_OK, 0); close_value();
            end
            bst_pkg::TAG_TEMPLATE: p_phase = bst_pkg::PH_TARR;
            default: tok_fail(bst_pkg::ERR_UNK_TAG);
        endcase
    endfunction

    function automatic bit hdr_pending();
        return p_phase == bst_pkg::PH_H0 || p_phase == bst_pkg::PH_H1 ||
               ((p_phase == bst_pkg::PH_ITAG || p_phase == bst_pkg::PH_IBYTES) &&
                p_purpose == bst_pkg::PU_HDR);
    endfunction

    function automatic void predict_tokens(logic [7:0] b, logic last);
        int sz;
        bst_pkg::err_t code;
        p_emitted = 0;
        if (!hdr_pending() && p_phase != bst_pkg::PH_DRAIN) p_body_left--;
        case (p_phase)
            bst_pkg::PH_H0:
                if (b != bst_pkg::HDR_BYTE0) tok_fail(bst_pkg::ERR_HEADER);
                else p_phase = bst_pkg::PH_H1;
            bst_pkg::PH_H1:
                if (b != bst_pkg::HDR_BYTE1) tok_fail(bst_pkg::ERR_HEADER);
                else
                begin
                    p_phase = bst_pkg::PH_ITAG; p_purpose = bst_pkg::PU_HDR;
                end
            bst_pkg::PH_ITAG:
            begin
                sz = tag_size(b);
                if (sz == 0)
                    tok_fail(p_purpose == bst_pkg::PU_HDR ? bst_pkg::ERR_HEADER :
                             bst_pkg::ERR_INT_TAG);
                else start_int(sz, p_purpose);
            end
            bst_pkg::PH_IBYTES:
            begin
                p_accum |= 64'(b) << (8 * ((p_int_size - p_int_left) & 7));
                p_int_left--;
                if (p_int_left == 0) finish_int();
            end
            bst_pkg::PH_VALUE: value_tag(b);
            bst_pkg::PH_TARR:
                if (b != bst_pkg::TAG_ARRAY) tok_fail(bst_pkg::ERR_TPL_ARR);
                else
                begin
                    p_phase = bst_pkg::PH_ITAG; p_purpose = bst_pkg::PU_TKEYS;
                end
            bst_pkg::PH_SBYTES:
            begin
                push_token(bst_pkg::TK_STRBYTE, 64'(b), p_ptr, in_key_slot(),
                           bst_pkg::ERR_OK, 0);
                p_str_left--;
                if (p_str_left == 0) close_value();
            end
            default: ;
        endcase
        if (last)
        begin
            if (!p_err_seen)
            begin
                if (hdr_pending()) code = bst_pkg::ERR_HEADER;
                else if (p_body_left != 0) code = bst_pkg::ERR_LENGTH;
                else if (!p_top_done) code = bst_pkg::ERR_TRUNC;
                else code = bst_pkg::ERR_OK;
                push_token(bst_pkg::TK_END, '0, 0, 0, code, 1);
            end
            tok_reset();
        end
    endfunction

    // ---------------- buffer generation ----------------
    byte_item_t frame_bytes[$];
    int value_budget;

    function automatic void put_byte(logic [7:0] b);
        byte_item_t it;
        it.data = b; it.last = 0;
        frame_bytes.push_back(it);
    endfunction

    function automatic void put_int(logic [63:0] v, int sz);
        put_byte(sz == 1 ? bst_pkg::TAG_INT8 : sz == 2 ? bst_pkg::TAG_INT16 :
                 sz == 4 ? bst_pkg::TAG_INT32 : bst_pkg::TAG_INT64);
        for (int i = 0; i < sz; i++) put_byte(v[8*i +: 8]);
    endfunction

    function automatic int rand_size();
        int r;
        r = $urandom_range(0, 3);
        return r == 0 ? 1 : r == 1 ? 2 : r == 2 ? 4 : 8;
    endfunction

    function automatic logic [63:0] rand_u64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic void put_string(bit short_only);
        int n;
        n = short_only ? $urandom_range(0, 3) : $urandom_range(0, 6);
        put_byte(bst_pkg::TAG_STRING);
        put_int(64'(n), $urandom_range(0, 3) == 0 ? 2 : 1);
        for (int i = 0; i < n; i++) put_byte(8'($urandom()));
    endfunction

    // random well-formed value, depth-limited
    function automatic void put_value(int depth, bit in_row);
        int k;
        int n;
        int rows;
        k = $urandom_range(0, 11);
        if (depth >= 17 || value_budget <= 0) k = k % 6;
        value_budget--;
        case (k)
            0, 1: put_int(rand_u64(), rand_size());
            2:
            begin
                put_byte(bst_pkg::TAG_REAL);
                for (int i = 0; i < 8; i++) put_byte(8'($urandom()));
            end
            3: put_byte($urandom_range(0, 2) == 0 ? bst_pkg::TAG_TRUE :
                        $urandom_range(0, 1) ? bst_pkg::TAG_FALSE : bst_pkg::TAG_NULL);
            4: put_string(0);
            5: if (in_row) put_byte(bst_pkg::TAG_SKIP); else put_byte(bst_pkg::TAG_NULL);
            6, 7:
            begin
                n = $urandom_range(0, 3);
                put_byte(bst_pkg::TAG_ARRAY); put_int(64'(n), 1);
                for (int i = 0; i < n; i++) put_value(depth + 1, 0);
            end
            8, 9:
            begin
                n = $urandom_range(0, 3);
                put_byte(bst_pkg::TAG_OBJECT); put_int(64'(n), 1);
                for (int i = 0; i < n; i++)
                begin
                    put_string(1);
                    put_value(depth + 1, 0);
                end
            end
            default:
            begin
                n = $urandom_range(0, 2);
                rows = $urandom_range(0, 2);
                put_byte(bst_pkg::TAG_TEMPLATE); put_byte(bst_pkg::TAG_ARRAY);
                put_int(64'(n), 1);
                for (int i = 0; i < n; i++) put_string(1);
                put_int(64'(rows), 1);
                if (n != 0)
                    for (int r = 0; r < rows; r++)
                        for (int i = 0; i < n; i++) put_value(depth + 1, 1);
            end
        endcase
    endfunction

    // wrap frame body with header; optionally corrupt
    function automatic void emit_frame(bit corrupt);
        byte_item_t body[$];
        int len;
        int pos;
        body = frame_bytes;
        frame_bytes.delete();
        len = body.size();
        put_byte(bst_pkg::HDR_BYTE0); put_byte(bst_pkg::HDR_BYTE1);
        if (corrupt && $urandom_range(0, 3) == 0) len = len + $urandom_range(0, 4) - 2;
        put_int(64'(len), $urandom_range(0, 1) ? 4 : 1);
        foreach (body[i]) frame_bytes.push_back(body[i]);
        if (corrupt)
        begin
            case ($urandom_range(0, 3))
                0: if (frame_bytes.size() > 1)
                       frame_bytes = frame_bytes[0:$urandom_range(0, frame_bytes.size()-2)];
                1:
                begin
                    pos = $urandom_range(0, frame_bytes.size() - 1);
                    frame_bytes[pos].data = 8'($urandom());
                end
                2: put_byte(8'($urandom()));
                default: ;
            endcase
        end
        frame_bytes[frame_bytes.size()-1].last = 1;
        foreach (frame_bytes[i]) pending_bytes.push_back(frame_bytes[i]);
        frame_bytes.delete();
    endfunction

    function automatic void raw_frame(logic [7:0] bytes_in[$]);
        foreach (bytes_in[i]) put_byte(bytes_in[i]);
        frame_bytes[frame_bytes.size()-1].last = 1;
        foreach (frame_bytes[i]) pending_bytes.push_back(frame_bytes[i]);
        frame_bytes.delete();
    endfunction

    // ---------------- clock, reset, stimulus ----------------
    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
    end

    initial
    begin
        fail_count = 0;
        stim_done = 0;
        tok_reset();
        send_idle_pct = 31;
        recv_idle_pct = 54;

        // directed: extremes, bad headers, each error but ERR_TRUNC, deep nesting
        raw_frame('{8'h00, 8'h01, bst_pkg::TAG_INT8, 8'h02, bst_pkg::TAG_INT8, 8'h80});
        raw_frame('{8'h00, 8'h01, bst_pkg::TAG_INT8, 8'h09, bst_pkg::TAG_INT64, 8'hff,
                    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h7f});
        raw_frame('{8'h01});
        raw_frame('{8'h00, 8'h01, 8'h07});
        raw_frame('{8'h00});
        raw_frame('{8'h00, 8'h01, bst_pkg::TAG_INT8, 8'h03, bst_pkg::TAG_ARRAY, 8'h0f, 8'h00});
        raw_frame('{8'h00, 8'h01, bst_pkg::TAG_INT8, 8'h04, bst_pkg::TAG_OBJECT,
                    bst_pkg::TAG_INT8, 8'h01, bst_pkg::TAG_TRUE});
        raw_frame('{8'h00, 8'h01, bst_pkg::TAG_INT8, 8'h01, bst_pkg::TAG_SKIP});
        raw_frame('{8'h00, 8'h01, bst_pkg::TAG_INT8, 8'h01, 8'hff});
        raw_frame('{8'h00, 8'h01, bst_pkg::TAG_INT8, 8'h02, bst_pkg::TAG_TEMPLATE, 8'h05});
        raw_frame('{8'h00, 8'h01, bst_pkg::TAG_INT8, 8'h03, bst_pkg::TAG_STRING,
                    bst_pkg::TAG_INT8, 8'hff});
        raw_frame('{8'h00, 8'h01, bst_pkg::TAG_INT8, 8'h06, bst_pkg::TAG_TEMPLATE,
                    bst_pkg::TAG_ARRAY, bst_pkg::TAG_INT8, 8'h00, bst_pkg::TAG_INT8, 8'h05});
        raw_frame('{8'h00, 8'h01, bst_pkg::TAG_INT8, 8'h05, bst_pkg::TAG_INT8, 8'h00,
                    bst_pkg::TAG_NULL});
        raw_frame('{8'h00, 8'h01, bst_pkg::TAG_INT8, 8'h07, bst_pkg::TAG_INT16, 8'h34});
        raw_frame('{8'h00, 8'h01, bst_pkg::TAG_INT8, 8'h02, bst_pkg::TAG_INT8, 8'h05, 8'h00});
        // too deep: 17 nested one-element arrays
        for (int i = 0; i < 17; i++)
        begin
            put_byte(bst_pkg::TAG_ARRAY); put_int(64'd1, 1);
        end
        put_byte(bst_pkg::TAG_FALSE);
        emit_frame(0);

        for (int phase_i = 0; phase_i < 3; phase_i++)
        begin
            while (pending_bytes.size() < 430)
            begin
                value_budget = $urandom_range(1, 12);
                put_value(0, 0);
                emit_frame($urandom_range(0, 4) == 0);
                if ($urandom_range(0, 15) == 0)
                begin
                    put_byte(8'($urandom()));
                    frame_bytes[0].last = 1'($urandom_range(0, 1));
                    pending_bytes.push_back(frame_bytes[0]); frame_bytes.delete();
                end
            end
            if (phase_i < 2)
            begin
                while (pending_bytes.size() > 80) @(posedge clk);
            end
            if (phase_i == 0)
            begin
                send_idle_pct = 54; recv_idle_pct = 31;
            end
            else if (phase_i == 1)
            begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
        end
        // make sure the last frame ends
        if (pending_bytes.size() > 0) pending_bytes[$].last = 1;
        stim_done = 1;
    end

    // ---------------- driver ----------------
    byte_item_t cur;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 0;
            s_tdata  <= '0;
            s_tlast  <= 0;
        end
        else
        begin
            if (!s_tvalid || s_tready)
            begin
                if (pending_bytes.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    cur = pending_bytes.pop_front();
                    s_tvalid <= 1;
                    s_tdata  <= cur.data;
                    s_tlast  <= cur.last;
                end
                else s_tvalid <= 0;
            end
        end
    end

    // ---------------- monitor ----------------
    token_exp_t want;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) m_tready <= 0;
        else
        begin
            if (s_tvalid && s_tready) predict_tokens(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                if (expected_tokens.size() == 0)
                begin
                    $display("%0t: unexpected token kind=%0d value=%h", $time,
                             m_tuser[3:0], m_tdata[63:0]);
                    fail_count++;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (m_tuser[3:0] !== want.kind || m_tdata[63:0] !== want.value ||
                        m_tdata[68:64] !== want.depth || m_tuser[4] !== want.is_key ||
                        m_tdata[72:69] !== want.err || m_tlast !== want.fin)
                    begin
                        $display({"%0t: token mismatch expected kind=%0d val=%h dep=%0d",
                                  " key=%0d err=%0d fin=%0d"},
                                 $time, want.kind, want.value, want.depth, want.is_key,
                                 want.err, want.fin);
                        $display({"%0t:                actual   kind=%0d val=%h dep=%0d",
                                  " key=%0d err=%0d fin=%0d"},
                                 $time, m_tuser[3:0], m_tdata[63:0], m_tdata[68:64],
                                 m_tuser[4], m_tdata[72:69], m_tlast);
                        fail_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ---------------- end of run ----------------
    initial
    begin
        cycle_count = 0;
        wait (rst_n);
        while (!(stim_done && pending_bytes.size() == 0 && !s_tvalid &&
                 expected_tokens.size() == 0) && cycle_count < 400000)
        begin
            @(posedge clk);
            cycle_count++;
        end
        if (cycle_count >= 400000)
        begin
            $display("simulation failed");
        end
        else
        begin
            repeat (60) @(posedge clk);
            if (fail_count == 0 && expected_tokens.size() == 0) $display("simulation ok");
            else $display("simulation failed");
        end
        $finish;
    end

endmodule
